[rtl/chkv_pkg.sv]
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared constants, codes and types of the chained hash key-value store.
// ----------------------------------------------------------------------------
package chkv_pkg;

    // Store geometry.
    localparam int NUM_BUCKETS = 16;
    localparam int MAX_ENTRIES = 64;

    // Field widths.
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int CNT_W  = 7;
    localparam int LINK_W = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int BKT_W  = $clog2(NUM_BUCKETS);

    // A link equal to MAX_ENTRIES marks the end of a chain.
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_ENTRIES);

    // Mask that selects the hashed part of the key.
    localparam logic [KEY_W-1:0] LOW32_MASK = KEY_W'(64'h0000_0000_FFFF_FFFF);

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_MISS,
        S_RESP
    } state_t;

    // One pool entry as held in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [LINK_W-1:0] next;
    } entry_t;

    // Commands from the controller to the allocator.
    typedef struct packed {
        logic              clear_all;
        logic              take;
        logic [ADDR_W-1:0] take_idx;
        logic              release_en;
        logic [ADDR_W-1:0] release_idx;
    } alloc_cmd_t;

    // Bucket of a key: its low 32 bits modulo the bucket count.
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] low;
        low = key & LOW32_MASK;
        return BKT_W'(low % NUM_BUCKETS);
    endfunction

endpackage

[rtl/chkv_req_if.sv]
// ----------------------------------------------------------------------------
// chkv_req_if
// Request channel: operation, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface chkv_req_if;
    logic                       valid;
    logic                       ready;
    chkv_pkg::op_t              op;
    logic [chkv_pkg::KEY_W-1:0] key;
    logic [chkv_pkg::VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

[rtl/chkv_rsp_if.sv]
// ----------------------------------------------------------------------------
// chkv_rsp_if
// Response channel: status, found value and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface chkv_rsp_if;
    logic                       valid;
    logic                       ready;
    chkv_pkg::status_t          status;
    logic [chkv_pkg::VAL_W-1:0] found_value;
    logic [chkv_pkg::CNT_W-1:0] entry_count;

    modport source (output valid, output status, output found_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found_value, input entry_count,
                    output ready);
endinterface

[rtl/chkv_ram.sv]
// ----------------------------------------------------------------------------
// chkv_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chkv_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/chkv_alloc.sv]
// ----------------------------------------------------------------------------
// chkv_alloc
// Entry pool allocator: used flags, lowest free entry and stored count.
// ----------------------------------------------------------------------------
module chkv_alloc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chkv_pkg::alloc_cmd_t          cmd,
    output logic                          free_valid,
    output logic [chkv_pkg::ADDR_W-1:0]   free_idx,
    output logic [chkv_pkg::CNT_W-1:0]    count
);

    logic [chkv_pkg::MAX_ENTRIES-1:0] used_reg, used_next;
    logic [chkv_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                             free_valid_reg, free_valid_next;
    logic [chkv_pkg::ADDR_W-1:0]      free_idx_reg, free_idx_next;

    // Update of the used flags and the count.
    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        if (cmd.clear_all)
        begin
            used_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (cmd.take)
            begin
                used_next[cmd.take_idx] = 1'b1;
                count_next              = count_reg + 1'b1;
            end
            if (cmd.release_en)
            begin
                used_next[cmd.release_idx] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    // Lowest numbered free entry, registered for the next operation.
    always_comb
    begin
        free_valid_next = 1'b0;
        free_idx_next   = '0;
        for (int i = chkv_pkg::MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_valid_next = 1'b1;
                free_idx_next   = chkv_pkg::ADDR_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            count_reg      <= '0;
            free_valid_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            used_reg       <= used_next;
            count_reg      <= count_next;
            free_valid_reg <= free_valid_next;
            free_idx_reg   <= free_idx_next;
        end
    end

    assign free_valid = free_valid_reg;
    assign free_idx   = free_idx_reg;
    assign count      = count_reg;

endmodule

[rtl/chained_hash_key_value_store_core.sv]
// Sequence: clear goes from idle straight to the response state. Other operations
// walk the bucket chain and pass through the miss state when the key is not found.
// Throughput: one request at a time, set by the chain walk through the entry
// memory (one link per cycle over its single read port); the next request is taken
// in the cycle after the response register loads. Reset: asynchronous, active low;
// all buckets empty, all entries free, count zero, no clearing pass.
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_core
// Separate chaining hash table over a fixed entry pool, with set, lookup,
// remove and clear requests and one response per request.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_core (
    input  logic       clk,
    input  logic       rst_n,
    chkv_req_if.sink   req,
    chkv_rsp_if.source rsp
);

    localparam int EW = $bits(chkv_pkg::entry_t);

    // Controller state.
    chkv_pkg::state_t             state_reg, state_next;
    chkv_pkg::op_t                op_reg, op_next;
    logic [chkv_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [chkv_pkg::VAL_W-1:0]   value_reg, value_next;
    logic [chkv_pkg::BKT_W-1:0]   bkt_reg, bkt_next;
    logic [chkv_pkg::ADDR_W-1:0]  cur_reg, cur_next;
    logic [chkv_pkg::LINK_W-1:0]  prev_reg, prev_next;
    chkv_pkg::entry_t             prev_data_reg, prev_data_next;
    logic [chkv_pkg::LINK_W-1:0]  steps_reg, steps_next;
    chkv_pkg::status_t            res_status_reg, res_status_next;
    logic [chkv_pkg::VAL_W-1:0]   res_value_reg, res_value_next;

    // Bucket heads with valid bits.
    logic [chkv_pkg::LINK_W-1:0]  head_reg [chkv_pkg::NUM_BUCKETS];
    logic [chkv_pkg::NUM_BUCKETS-1:0] head_valid_reg;
    logic                         head_we;
    logic                         head_clear;
    logic [chkv_pkg::LINK_W-1:0]  head_wdata;
    logic [chkv_pkg::BKT_W-1:0]   in_bkt;
    logic [chkv_pkg::LINK_W-1:0]  in_head;
    logic [chkv_pkg::LINK_W-1:0]  cur_head;

    // Output register.
    logic                         rsp_valid_reg, rsp_valid_next;
    chkv_pkg::status_t            rsp_status_reg;
    logic [chkv_pkg::VAL_W-1:0]   rsp_value_reg;
    logic [chkv_pkg::CNT_W-1:0]   rsp_count_reg;
    logic                         rsp_load;

    // Entry memory and allocator.
    logic                         ram_we, ram_re;
    logic [chkv_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    chkv_pkg::entry_t             ram_wdata, ram_rdata;
    logic [EW-1:0]                ram_rdata_raw;
    chkv_pkg::alloc_cmd_t         acmd;
    logic                         free_valid;
    logic [chkv_pkg::ADDR_W-1:0]  free_idx;
    logic [chkv_pkg::CNT_W-1:0]   count;

    chkv_ram #(
        .DATA_W (EW),
        .DEPTH  (chkv_pkg::MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = chkv_pkg::entry_t'(ram_rdata_raw);

    chkv_alloc u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (acmd),
        .free_valid (free_valid),
        .free_idx   (free_idx),
        .count      (count)
    );

    // Head lookups; an empty bucket reads as the end of chain.
    assign in_bkt   = chkv_pkg::bucket_of(req.key);
    assign in_head  = head_valid_reg[in_bkt] ? head_reg[in_bkt] : chkv_pkg::NIL_LINK;
    assign cur_head = head_valid_reg[bkt_reg] ? head_reg[bkt_reg] : chkv_pkg::NIL_LINK;

    // Next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        bkt_next        = bkt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_data_next  = prev_data_reg;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        head_we         = 1'b0;
        head_clear      = 1'b0;
        head_wdata      = chkv_pkg::NIL_LINK;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = cur_reg;
        acmd            = '0;
        req.ready       = 1'b0;
        rsp_load        = 1'b0;

        case (state_reg)
            chkv_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next         = req.op;
                    key_next        = req.key;
                    value_next      = req.value;
                    bkt_next        = in_bkt;
                    prev_next       = chkv_pkg::NIL_LINK;
                    steps_next      = '0;
                    res_status_next = chkv_pkg::ST_OK;
                    res_value_next  = '0;
                    if (req.op == chkv_pkg::OP_CLEAR)
                    begin
                        acmd.clear_all = 1'b1;
                        head_clear     = 1'b1;
                        state_next     = chkv_pkg::S_RESP;
                    end
                    else if (in_head >= chkv_pkg::NIL_LINK)
                    begin
                        state_next = chkv_pkg::S_MISS;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = in_head[chkv_pkg::ADDR_W-1:0];
                        cur_next   = in_head[chkv_pkg::ADDR_W-1:0];
                        state_next = chkv_pkg::S_CMP;
                    end
                end
            end

            chkv_pkg::S_CMP:
            begin
                if (ram_rdata.key == key_reg)
                begin
                    state_next = chkv_pkg::S_RESP;
                    case (op_reg)
                        chkv_pkg::OP_SET:
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = cur_reg;
                            ram_wdata       = ram_rdata;
                            ram_wdata.value = value_reg;
                        end
                        chkv_pkg::OP_LOOKUP:
                        begin
                            res_value_next = ram_rdata.value;
                        end
                        chkv_pkg::OP_REMOVE:
                        begin
                            res_value_next   = ram_rdata.value;
                            acmd.release_en  = 1'b1;
                            acmd.release_idx = cur_reg;
                            if (prev_reg == chkv_pkg::NIL_LINK)
                            begin
                                head_we    = 1'b1;
                                head_wdata = ram_rdata.next;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = prev_reg[chkv_pkg::ADDR_W-1:0];
                                ram_wdata      = prev_data_reg;
                                ram_wdata.next = ram_rdata.next;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (ram_rdata.next >= chkv_pkg::NIL_LINK ||
                         steps_reg == chkv_pkg::LINK_W'(chkv_pkg::MAX_ENTRIES - 1))
                begin
                    state_next = chkv_pkg::S_MISS;
                end
                else
                begin
                    // Follow the link: one chain entry per cycle.
                    ram_re         = 1'b1;
                    ram_raddr      = ram_rdata.next[chkv_pkg::ADDR_W-1:0];
                    prev_next      = chkv_pkg::LINK_W'(cur_reg);
                    prev_data_next = ram_rdata;
                    cur_next       = ram_rdata.next[chkv_pkg::ADDR_W-1:0];
                    steps_next     = steps_reg + 1'b1;
                end
            end

            chkv_pkg::S_MISS:
            begin
                state_next = chkv_pkg::S_RESP;
                if (op_reg == chkv_pkg::OP_SET)
                begin
                    if (free_valid)
                    begin
                        // Prepend a fresh entry to the bucket chain.
                        ram_we          = 1'b1;
                        ram_waddr       = free_idx;
                        ram_wdata.key   = key_reg;
                        ram_wdata.value = value_reg;
                        ram_wdata.next  = cur_head;
                        head_we         = 1'b1;
                        head_wdata      = chkv_pkg::LINK_W'(free_idx);
                        acmd.take       = 1'b1;
                        acmd.take_idx   = free_idx;
                    end
                    else
                    begin
                        res_status_next = chkv_pkg::ST_FULL;
                    end
                end
                else
                begin
                    res_status_next = chkv_pkg::ST_NOT_FOUND;
                end
            end

            chkv_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = chkv_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = chkv_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= chkv_pkg::S_IDLE;
            head_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (head_clear)
            begin
                head_valid_reg <= '0;
            end
            else if (head_we)
            begin
                head_valid_reg[bkt_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_data_reg  <= prev_data_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (head_we)
        begin
            head_reg[bkt_reg] <= head_wdata;
        end
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_value_reg  <= res_value_reg;
            rsp_count_reg  <= count;
        end
    end

    // Response register handshake.
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_value = rsp_value_reg;
    assign rsp.entry_count = rsp_count_reg;

    // The entry count never exceeds the pool size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= chkv_pkg::CNT_W'(chkv_pkg::MAX_ENTRIES))
        else $error("entry count above pool size");

    // A clear request leaves the store empty on the next cycle.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == chkv_pkg::OP_CLEAR)
        |=> (count == '0 && head_valid_reg == '0))
        else $error("clear did not empty the store");

    // Entry memory is written only when a chain walk resolves.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == chkv_pkg::S_CMP || state_reg == chkv_pkg::S_MISS))
        else $error("entry write outside walk resolution");

    // In the miss state, a free entry is reported only while the pool is not full.
    a_free_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chkv_pkg::S_MISS && free_valid)
        |-> count < chkv_pkg::CNT_W'(chkv_pkg::MAX_ENTRIES))
        else $error("free entry reported with full pool");

endmodule
